// ----- sv/tcmn_pkg.sv -----
// ----------------------------------------------------------------------------
// tcmn_pkg
// Types and constants shared by the touch channel min/max normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcmn_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 4;
    localparam int CMD_W    = 3;
    localparam int CAL_W    = 8;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REPORT_ONCE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CAL_CLEAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MIN_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAX_RESTART = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 2'd1;

    localparam logic [SAMPLE_W-1:0] MIN_RESET = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] MAX_RESET = 16'h0000;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd255;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic                last_of_scan;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [SAMPLE_W-1:0] value;
        logic [7:0]          check_byte;
        logic                last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] dividend;
        logic [SAMPLE_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_DIVIDE,
        ST_FINISH
    } norm_state_t;

endpackage

`default_nettype wire

// ----- sv/touch_channel_minmax_normalizer.sv -----
// ----------------------------------------------------------------------------
// touch_channel_minmax_normalizer
// Keeps per-channel min/max during calibration countdowns and, while armed or
// continuous, reports samples normalized to 0..255 over the span (raw if raw
// or uncalibrated, offset if no span), with a running XOR check byte per frame.
// ----------------------------------------------------------------------------
//  channel   ports                                 payload
//  input     s_valid / s_ready / s_item            tcmn_pkg::in_item_t
//  result    m_valid / m_ready / m_item            tcmn_pkg::out_item_t
//  config    cfg_valid / cfg_ready / cfg_index     cfg_data (1 bit)
//
//  a sample item passes load, diff and finish when raw, uncalibrated, offset-only
//  or clipped, and the serial divider (1 scale + 8 steps) between diff and finish
//  otherwise; an unreported sample ends after diff, or after load if out of range
//  a control command is taken in idle; s_ready is low while an item is worked
//  results wait in an output register; a stalled m_ready holds the next item
//  in its final cycle only. synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_channel_minmax_normalizer #(
    parameter int CHANNELS  = 12,
    parameter int CAL_SCANS = 255
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire tcmn_pkg::in_item_t                  s_item,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tcmn_pkg::out_item_t                      m_item,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tcmn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic                                cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [tcmn_pkg::CAL_W-1:0] CAL_START = tcmn_pkg::CAL_W'(CAL_SCANS);

    tcmn_pkg::norm_state_t state_reg, state_next;

    logic [tcmn_pkg::SAMPLE_W-1:0] min_store_reg [CHANNELS];
    logic [tcmn_pkg::SAMPLE_W-1:0] max_store_reg [CHANNELS];
    logic [tcmn_pkg::CAL_W-1:0]    min_cal_left_reg;
    logic [tcmn_pkg::CAL_W-1:0]    max_cal_left_reg;
    logic                          report_armed_reg;
    logic [7:0]                    frame_xor_reg;
    logic                          raw_mode_reg;
    logic                          continuous_reg;

    logic [tcmn_pkg::CHAN_W-1:0]   ch_reg;
    logic [tcmn_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          last_reg;
    logic [tcmn_pkg::SAMPLE_W-1:0] lo_reg;
    logic [tcmn_pkg::SAMPLE_W-1:0] hi_reg;
    logic [tcmn_pkg::SAMPLE_W-1:0] val_reg;

    logic                          m_valid_reg;
    tcmn_pkg::out_item_t           m_item_reg;

    logic                          in_accept;
    logic                          in_range;
    logic [IDX_W-1:0]              ch_idx;
    logic [tcmn_pkg::SAMPLE_W-1:0] min_rd;
    logic [tcmn_pkg::SAMPLE_W-1:0] max_rd;
    logic [tcmn_pkg::SAMPLE_W-1:0] lo_new;
    logic [tcmn_pkg::SAMPLE_W-1:0] hi_new;

    logic                          report_on;
    logic                          pass_through;
    logic                          span_ok;
    logic                          clip;
    logic [tcmn_pkg::SAMPLE_W-1:0] offset;
    logic [tcmn_pkg::SAMPLE_W-1:0] span;
    logic [7:0]                    xor_new;

    logic                          out_load;
    logic                          scan_end;
    tcmn_pkg::div_req_t            div_req;
    logic                          div_done;
    logic [7:0]                    div_q;

    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign in_range  = {1'b0, ch_reg} < (tcmn_pkg::CHAN_W + 1)'(CHANNELS);
    assign ch_idx    = ch_reg[IDX_W-1:0];
    assign min_rd    = min_store_reg[ch_idx];
    assign max_rd    = max_store_reg[ch_idx];

    // calibration compare against the stored extremes
    always_comb begin
        lo_new = min_rd;
        hi_new = max_rd;
        if (min_cal_left_reg != '0 && sample_reg < min_rd) begin
            lo_new = sample_reg;
        end
        if (max_cal_left_reg != '0 && sample_reg > max_rd) begin
            hi_new = sample_reg;
        end
    end

    assign report_on    = report_armed_reg || continuous_reg;
    assign pass_through = raw_mode_reg || (lo_reg == tcmn_pkg::MIN_RESET);
    assign span_ok      = hi_reg > lo_reg;
    // with a valid span and no pass-through, sample at or above max saturates
    assign clip         = sample_reg >= hi_reg;
    assign offset       = (sample_reg > lo_reg) ? (sample_reg - lo_reg) : '0;
    assign span         = hi_reg - lo_reg;
    assign xor_new      = frame_xor_reg ^ val_reg[15:8] ^ val_reg[7:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcmn_pkg::ST_IDLE: begin
                if (in_accept && s_item.command == tcmn_pkg::CMD_SAMPLE) begin
                    state_next = tcmn_pkg::ST_LOAD;
                end
            end
            tcmn_pkg::ST_LOAD: begin
                state_next = in_range ? tcmn_pkg::ST_DIFF : tcmn_pkg::ST_IDLE;
            end
            tcmn_pkg::ST_DIFF: begin
                priority if (!report_on) begin
                    state_next = tcmn_pkg::ST_IDLE;
                end else if (pass_through || !span_ok || clip) begin
                    state_next = tcmn_pkg::ST_FINISH;
                end else begin
                    state_next = tcmn_pkg::ST_DIVIDE;
                end
            end
            tcmn_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = tcmn_pkg::ST_FINISH;
                end
            end
            tcmn_pkg::ST_FINISH: begin
                if (out_load) begin
                    state_next = tcmn_pkg::ST_IDLE;
                end
            end
            default: state_next = tcmn_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready          = 1'b0;
        out_load         = 1'b0;
        scan_end         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = offset;
        div_req.divisor  = span;
        unique case (state_reg)
            tcmn_pkg::ST_IDLE: s_ready = 1'b1;
            tcmn_pkg::ST_LOAD: scan_end = !in_range;
            tcmn_pkg::ST_DIFF: begin
                scan_end      = !report_on;
                div_req.start = report_on && !pass_through && span_ok && !clip;
            end
            tcmn_pkg::ST_DIVIDE: ;
            tcmn_pkg::ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
                scan_end = out_load;
            end
            default: ;
        endcase
    end

    tcmn_div8 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // control and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tcmn_pkg::ST_IDLE;
            min_cal_left_reg <= CAL_START;
            max_cal_left_reg <= CAL_START;
            report_armed_reg <= 1'b0;
            frame_xor_reg    <= 8'd0;
            raw_mode_reg     <= 1'b0;
            continuous_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                min_store_reg[i] <= tcmn_pkg::MIN_RESET;
                max_store_reg[i] <= tcmn_pkg::MAX_RESET;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tcmn_pkg::REG_RAW_MODE) begin
                    raw_mode_reg <= cfg_data;
                end
                if (cfg_index == tcmn_pkg::REG_CONTINUOUS) begin
                    continuous_reg <= cfg_data;
                end
            end

            if (in_accept) begin
                unique case (s_item.command)
                    tcmn_pkg::CMD_REPORT_ONCE: report_armed_reg <= 1'b1;
                    tcmn_pkg::CMD_CAL_CLEAR: begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            min_store_reg[i] <= tcmn_pkg::MIN_RESET;
                            max_store_reg[i] <= tcmn_pkg::MAX_RESET;
                        end
                    end
                    tcmn_pkg::CMD_MIN_RESTART: min_cal_left_reg <= CAL_START;
                    tcmn_pkg::CMD_MAX_RESTART: max_cal_left_reg <= CAL_START;
                    default: ;
                endcase
            end

            if (state_reg == tcmn_pkg::ST_LOAD && in_range) begin
                min_store_reg[ch_idx] <= lo_new;
                max_store_reg[ch_idx] <= hi_new;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // end of scan: countdowns tick, frame closes
            if (scan_end && last_reg) begin
                if (min_cal_left_reg != '0) begin
                    min_cal_left_reg <= min_cal_left_reg - tcmn_pkg::CAL_W'(1);
                end
                if (max_cal_left_reg != '0) begin
                    max_cal_left_reg <= max_cal_left_reg - tcmn_pkg::CAL_W'(1);
                end
                report_armed_reg <= 1'b0;
                frame_xor_reg    <= 8'd0;
            end else if (out_load) begin
                frame_xor_reg <= xor_new;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ch_reg     <= s_item.channel;
            sample_reg <= s_item.sample;
            last_reg   <= s_item.last_of_scan;
        end
        if (state_reg == tcmn_pkg::ST_LOAD) begin
            lo_reg <= lo_new;
            hi_reg <= hi_new;
        end
        if (state_reg == tcmn_pkg::ST_DIFF) begin
            priority if (pass_through) begin
                val_reg <= sample_reg;
            end else if (!span_ok) begin
                val_reg <= offset;
            end else begin
                val_reg <= tcmn_pkg::FULL_SCALE;
            end
        end else if (state_reg == tcmn_pkg::ST_DIVIDE && div_done) begin
            val_reg <= {8'd0, div_q};
        end
        if (out_load) begin
            m_item_reg.out_channel   <= ch_reg;
            m_item_reg.value         <= val_reg;
            m_item_reg.check_byte    <= xor_new;
            m_item_reg.last_of_frame <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == tcmn_pkg::ST_DIVIDE)
        else $error("divider result outside of divide state");

    // the min countdown only jumps back to full on its restart command
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_item.command != tcmn_pkg::CMD_MIN_RESTART
        |=> min_cal_left_reg == $past(min_cal_left_reg))
        else $error("min countdown changed by a foreign command");

    // closing a frame clears the running check
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && last_reg |=> frame_xor_reg == 8'd0 && m_valid_reg)
        else $error("frame check not cleared at end of frame");

    // a normalized value from the divider never exceeds full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !pass_through && span_ok |-> val_reg <= tcmn_pkg::FULL_SCALE)
        else $error("normalized value above full scale");
`endif

endmodule

`default_nettype wire

// ----- sv/tcmn_div8.sv -----
// ----------------------------------------------------------------------------
// tcmn_div8
// Serial scale-and-divide: q = (dividend * 255) / divisor, for dividend <
// divisor, so q fits in 8 bits. One shared 24-bit subtractor does the
// multiply by 255 in a single scale step and then one restoring step per quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcmn_div8 (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcmn_pkg::div_req_t req,
    output logic                   done,
    output logic [7:0]             quotient
);

    logic        busy_reg;
    logic        mul_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic [23:0] rem_reg;
    logic [15:0] dividend_reg;
    logic [15:0] divisor_reg;
    logic [7:0]  q_reg;

    logic [23:0] sub_b;
    logic [24:0] diff;
    logic        borrow;

    // shared subtractor: d*256 - d first, then remainder - divisor*2^k
    always_comb begin
        if (mul_reg) begin
            sub_b = {8'd0, dividend_reg};
        end else begin
            sub_b = {8'd0, divisor_reg} << step_reg;
        end
        diff   = {1'b0, rem_reg} - {1'b0, sub_b};
        borrow = diff[24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                mul_reg  <= 1'b1;
                step_reg <= 3'd7;
            end else if (busy_reg) begin
                if (mul_reg) begin
                    mul_reg <= 1'b0;
                end else if (step_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg      <= {req.dividend, 8'd0};
            dividend_reg <= req.dividend;
            divisor_reg  <= req.divisor;
            q_reg        <= 8'd0;
        end else if (busy_reg) begin
            if (mul_reg) begin
                rem_reg <= diff[23:0];
            end else begin
                if (!borrow) begin
                    rem_reg <= diff[23:0];
                end
                q_reg <= {q_reg[6:0], ~borrow};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

`ifndef SYNTHESIS
    // the multiply step always comes first after a start
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && mul_reg && step_reg == 3'd7)
        else $error("divider did not begin with the scale step");

    // done pulses once, at the end of a busy run
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ----- test/touch_norm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_norm_checker
// Watches the input, result and register channels of the normalizer, keeps
// its own copy of the calibration stores and countdowns, works out the
// report each accepted sample should produce and compares every result
// field by field against the oldest pending report.
// ----------------------------------------------------------------------------

module touch_norm_checker #(
    parameter int CHANNELS  = 12,
    parameter int CAL_SCANS = 255
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  tcmn_pkg::in_item_t                   s_item,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  tcmn_pkg::out_item_t                  m_item,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tcmn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic                                 cfg_data,
    output int                                   fail_count,
    output int                                   pending
);

    import tcmn_pkg::*;

    localparam int SLOTS = 16;

    logic [SAMPLE_W-1:0] level_min [SLOTS];
    logic [SAMPLE_W-1:0] level_max [SLOTS];
    logic [CAL_W-1:0]    min_scans_left;
    logic [CAL_W-1:0]    max_scans_left;
    logic                single_report;
    logic [7:0]          frame_check;
    logic                raw_mode;
    logic                continuous;
    out_item_t           expected_reports[$];
    out_item_t           oldest;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic clear_levels();
        for (int i = 0; i < SLOTS; i++) begin
            level_min[i] = MIN_RESET;
            level_max[i] = MAX_RESET;
        end
    endtask

    // offset over the calibrated span, scaled to 0..255; the sample when uncalibrated, the offset with no span
    function automatic logic [SAMPLE_W-1:0] span_scale(logic [SAMPLE_W-1:0] smp,
                                                       logic [SAMPLE_W-1:0] lo,
                                                       logic [SAMPLE_W-1:0] hi);
        int unsigned offset;
        int unsigned ratio;
        if (lo == MIN_RESET)
            return smp;
        offset = (smp > lo) ? int'(smp - lo) : 0;
        if (hi > lo) begin
            ratio = (offset * 255) / int'(hi - lo);
            return (ratio < 255) ? SAMPLE_W'(ratio) : FULL_SCALE;
        end
        return SAMPLE_W'(offset);
    endfunction

    task automatic predict_report(input in_item_t it);
        out_item_t           rep;
        logic [SAMPLE_W-1:0] val;
        case (it.command)
            CMD_REPORT_ONCE: single_report = 1'b1;
            CMD_CAL_CLEAR:   clear_levels();
            CMD_MIN_RESTART: min_scans_left = CAL_W'(CAL_SCANS);
            CMD_MAX_RESTART: max_scans_left = CAL_W'(CAL_SCANS);
            CMD_SAMPLE: begin
                if (it.channel < CHANNELS) begin
                    if (min_scans_left != 0 && it.sample < level_min[it.channel])
                        level_min[it.channel] = it.sample;
                    if (max_scans_left != 0 && it.sample > level_max[it.channel])
                        level_max[it.channel] = it.sample;
                    if (single_report || continuous) begin
                        val = raw_mode ? it.sample
                            : span_scale(it.sample, level_min[it.channel],
                                         level_max[it.channel]);
                        frame_check = frame_check ^ val[15:8] ^ val[7:0];
                        rep.out_channel   = it.channel;
                        rep.value         = val;
                        rep.check_byte    = frame_check;
                        rep.last_of_frame = it.last_of_scan;
                        expected_reports.push_back(rep);
                    end
                end
                // end of scan, also for a channel out of range
                if (it.last_of_scan) begin
                    if (min_scans_left != 0)
                        min_scans_left = min_scans_left - CAL_W'(1);
                    if (max_scans_left != 0)
                        max_scans_left = max_scans_left - CAL_W'(1);
                    single_report = 1'b0;
                    frame_check   = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_levels();
            min_scans_left = CAL_W'(CAL_SCANS);
            max_scans_left = CAL_W'(CAL_SCANS);
            single_report  = 1'b0;
            frame_check    = '0;
            raw_mode       = 1'b0;
            continuous     = 1'b0;
            expected_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: channel %0d value %0d",
                           m_item.out_channel, m_item.value);
                    fail_count++;
                end else begin
                    oldest = expected_reports.pop_front();
                    check_field("out_channel", oldest.out_channel, m_item.out_channel);
                    check_field("value", oldest.value, m_item.value);
                    check_field("check_byte", oldest.check_byte, m_item.check_byte);
                    check_field("last_of_frame", oldest.last_of_frame,
                                m_item.last_of_frame);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_RAW_MODE)
                    raw_mode = cfg_data;
                else if (cfg_index == REG_CONTINUOUS)
                    continuous = cfg_data;
            end
            if (s_valid && s_ready)
                predict_report(s_item);
        end
        pending = expected_reports.size();
    end

endmodule

// ----- test/touch_channel_minmax_normalizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_channel_minmax_normalizer_tb
// Drives directed and random scans through the normalizer under several
// flow-control patterns and register settings; the checker beside the block
// predicts every report and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------

module touch_channel_minmax_normalizer_tb;

    import tcmn_pkg::*;

    localparam int N_CH          = 12;
    localparam int CAL           = 255;
    localparam int ITEMS_PER_RUN = 375;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data  = 1'b0;

    int                   fail_count;
    int                   pending;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_req       = 1'b0;
    bit                   held           = 1'b0;
    int                   cycle_count    = 0;
    int                   items_sent     = 0;
    logic [SAMPLE_W-1:0]  base_level [N_CH];
    int                   spread;

    touch_channel_minmax_normalizer #(
        .CHANNELS  (N_CH),
        .CAL_SCANS (CAL)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_norm_checker #(
        .CHANNELS  (N_CH),
        .CAL_SCANS (CAL)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                           logic [SAMPLE_W-1:0] smp, logic lst);
        in_item_t it;
        it.command      = cmd;
        it.channel      = ch;
        it.sample       = smp;
        it.last_of_scan = lst;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_sample(input int ch, input int smp, input logic lst);
        send_item(make_item(CMD_SAMPLE, CHAN_W'(ch), SAMPLE_W'(smp), lst));
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd);
        send_item(make_item(cmd, CHAN_W'($urandom_range(15)),
                            SAMPLE_W'($urandom_range(65535)), 1'($urandom_range(1))));
    endtask

    task automatic await_drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // registers only change with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        await_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic raw, input logic cont);
        write_reg(REG_RAW_MODE, raw);
        write_reg(REG_CONTINUOUS, cont);
    endtask

    task automatic new_levels();
        for (int c = 0; c < N_CH; c++)
            base_level[c] = SAMPLE_W'($urandom_range(60000));
        spread = $urandom_range(16, 4000);
    endtask

    // one scan over a run of neighboring channels, with occasional noise
    task automatic run_scan(input int arm_pct);
        int n;
        int first;
        int smp;
        if ($urandom_range(99) < arm_pct)
            send_command(CMD_REPORT_ONCE);
        if ($urandom_range(199) == 0)
            send_command(CMD_CAL_CLEAR);
        if ($urandom_range(99) < 2)
            send_command(CMD_MIN_RESTART);
        if ($urandom_range(99) < 2)
            send_command(CMD_MAX_RESTART);
        n     = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(4, N_CH);
        first = $urandom_range(N_CH - n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 3)
                send_item(make_item(CMD_W'($urandom_range(7)), CHAN_W'($urandom_range(15)),
                                    SAMPLE_W'($urandom_range(65535)),
                                    1'($urandom_range(1))));
            if ($urandom_range(9) == 0)
                smp = $urandom_range(65535);
            else
                smp = base_level[first + i] + $urandom_range(spread);
            if (smp > 65535)
                smp = 65535;
            send_sample(first + i, smp, i == n - 1);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_mode(1'b0, 1'b0);

        // directed: uncalibrated, spans, clipping, ignored items, clear, restart
        send_sample(0, 16'hFFFF, 1'b0);
        send_command(CMD_REPORT_ONCE);
        send_sample(1, 16'hFFFF, 1'b0);
        send_sample(0, 100, 1'b0);
        send_sample(15, 1234, 1'b1);
        send_sample(2, 500, 1'b0);
        send_item(make_item(CMD_REPORT_ONCE, 4'd0, 16'd0, 1'b0));
        send_sample(2, 400, 1'b0);
        send_sample(2, 600, 1'b0);
        send_sample(2, 450, 1'b0);
        send_sample(2, 0, 1'b0);
        send_item(make_item(3'd5, 4'd3, 16'h5A5A, 1'b1));
        send_item(make_item(3'd6, 4'd12, 16'hA5A5, 1'b0));
        send_item(make_item(3'd7, 4'd15, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_CAL_CLEAR, 4'd0, 16'd0, 1'b0));
        send_sample(3, 0, 1'b0);
        send_sample(3, 7, 1'b0);
        send_sample(11, 16'h8000, 1'b1);
        send_sample(11, 16'h7FFF, 1'b0);
        send_item(make_item(CMD_MIN_RESTART, 4'd0, 16'd0, 1'b0));
        send_item(make_item(CMD_MAX_RESTART, 4'd0, 16'd0, 1'b0));
        send_command(CMD_REPORT_ONCE);
        send_sample(5, 16'hFFFF, 1'b0);
        send_sample(5, 1, 1'b1);

        for (int run = 0; run < 4; run++) begin
            case (run)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_mode(1'b0, 1'b1); end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  set_mode(1'b1, 1'b1); end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; set_mode(1'b0, 1'b0); end
                default: begin
                    send_idle_pct = 14; recv_stall_pct = 14; set_mode(1'b0, 1'b1);
                end
            endcase
            new_levels();
            items_sent = 0;
            while (items_sent < ITEMS_PER_RUN) begin
                run_scan(run == 2 ? 60 : 10);
                // long result stall with the sender still pushing
                if (run == 0 && !held && items_sent >= ITEMS_PER_RUN / 2) begin
                    await_drain();
                    hold_req = 1'b1;
                    for (int i = 0; i < 40; i++)
                        send_sample(i % N_CH, $urandom_range(65535), i % N_CH == N_CH - 1);
                    held = 1'b1;
                end
            end
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tcmn_pkg.sv
sv/tcmn_div8.sv
sv/touch_channel_minmax_normalizer.sv
test/touch_norm_checker.sv
test/touch_channel_minmax_normalizer_tb.sv
